// ----- hdl/mandelbrot_escape_pixel_top_assert.svh -----
// Assertion macros used by the verification-side checker of the escape-time block.
// Each macro expands to one labeled concurrent assertion clocked on i_clk.
`ifndef MANDELBROT_ESCAPE_PIXEL_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_PIXEL_TOP_ASSERT_SVH

// Checked only while the block is out of reset.
`define MEP_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define MEP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/mep_pkg.sv -----
// Shared types, constants and helper functions of the escape-time pixel engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package mep_pkg;

    // Default parameter values.
    localparam int MAX_ITER_DEF   = 256;
    localparam int IMG_WIDTH_DEF  = 800;
    localparam int IMG_HEIGHT_DEF = 600;
    localparam int FRAC_BITS_DEF  = 24;

    // Width of the working sums before saturation, and of a signed pixel offset.
    localparam int SAT_W = 72;
    localparam int OFF_W = 13;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_RE,
        CFG_CENTER_IM,
        CFG_ZOOM,
        CFG_STEP_RE,
        CFG_STEP_IM,
        CFG_BOUND
    } t_cfg_idx;

    // Register reset values, Q7.24.
    localparam logic signed [31:0] RST_CENTER_RE = 32'shFF40_0000;
    localparam logic signed [31:0] RST_CENTER_IM = 32'sh0000_0000;
    localparam logic signed [31:0] RST_ZOOM      = 32'sh0100_0000;
    localparam logic [30:0]        RST_STEP_RE   = 31'd41943;
    localparam logic [30:0]        RST_STEP_IM   = 31'd55924;
    localparam logic [30:0]        RST_BOUND     = 31'd1677721600;

    localparam logic [31:0] ARGB_BLACK = 32'hFF00_0000;

    // Colour ramp: threshold table over the 8-bit coefficient.
    localparam int          THR_W      = 13;
    localparam logic [63:0] COEF_SCALE = 64'd4228250625;   // 255^4
    typedef logic [255:0][THR_W-1:0] t_thr_tab;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_OFF,
        ST_MAP_T,
        ST_MAP_ZOOM,
        ST_MAP_C,
        ST_IT_XX,
        ST_IT_YY,
        ST_IT_XY,
        ST_IT_CHK,
        ST_COEF,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_OFF,
        MUL_ZOOM,
        MUL_XX,
        MUL_YY,
        MUL_XY
    } t_mul_sel;

    typedef struct packed {
        logic       start;
        t_mul_sel   mul_sel;
        logic       im;
        logic       ld_t;
        logic       ld_c;
        logic       ld_x2;
        logic       ld_y2;
        logic       upd;
        logic       coef_step;
        logic [2:0] coef_bit;
        logic       ld_out;
    } t_cmd;

    typedef struct packed {
        logic escaped;
        logic last;
    } t_stat;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic fits;
        fits = (&v[SAT_W-1:31]) || !(|v[SAT_W-1:31]);
        if (fits) begin
            return v[31:0];
        end else if (v[SAT_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

    // Entry k is the smallest count n with k^4 * max_iter <= n * 255^4.
    function automatic t_thr_tab thr_table(input int unsigned max_iter);
        t_thr_tab    tab;
        logic [63:0] num;
        int          k;
        for (k = 0; k < 256; k++) begin
            num = 64'(k) * 64'(k) * 64'(k) * 64'(k) * 64'(max_iter);
            tab[8'(k)] = THR_W'((num + COEF_SCALE - 64'd1) / COEF_SCALE);
        end
        return tab;
    endfunction

endpackage

// ----- hdl/mandelbrot_escape_pixel_top.sv -----
// Escape-time pixel engine: one pixel coordinate in, one iteration count and colour word out.
// Each pixel maps to a point c in signed Q7.24 and iterates z = z^2 + c from z = c until
// |z|^2 passes the escape bound or MAX_ITER iterations are done. All products go through a
// single shared signed 32x32 multiplier, so the work of a pixel runs as a sequence from acceptance
// to its result register: the coordinate mapping, then for each iteration the three products
// and the radius test with update, then the colour coefficient search and the load of the result.
// One pixel is worked on at a time; a finished word waits in the output register while the
// next pixel is taken. Configuration writes are always ready and are meant for idle periods.
// Depends on mep_pkg, mep_ctrl and mep_dp.
module mandelbrot_escape_pixel_top #(
    parameter int MAX_ITER   = mep_pkg::MAX_ITER_DEF,
    parameter int IMG_WIDTH  = mep_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = mep_pkg::IMG_HEIGHT_DEF,
    parameter int FRAC_BITS  = mep_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [9:0]                    i_pixel_col,
    input  logic [9:0]                    i_pixel_row,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [8:0]                    o_iter_count,
    output logic                          o_in_set,
    output logic [31:0]                   o_argb_color,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mep_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    mep_pkg::t_cmd  cmd;
    mep_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    mep_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mep_dp #(
        .MAX_ITER   (MAX_ITER),
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_pixel_col  (i_pixel_col),
        .i_pixel_row  (i_pixel_row),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_iter_count (o_iter_count),
        .o_in_set     (o_in_set),
        .o_argb_color (o_argb_color)
    );

endmodule

// ----- hdl/mep_ctrl.sv -----
// Sequencer of the escape-time engine: maps the pixel, runs the iteration loop,
// searches the colour coefficient and hands the word to the output. Uses mep_pkg.
module mep_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  mep_pkg::t_stat   i_stat,
    output mep_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] TOP_BIT = 3'd7;

    mep_pkg::t_state r_state, n_state;
    logic            r_im, n_im;
    logic [2:0]      r_bit, n_bit;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mep_pkg::ST_IDLE;
            r_im        <= 1'b0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_im        <= n_im;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_im    = r_im;
        n_bit   = r_bit;
        o_cmd   = '0;
        case (r_state)
            mep_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_im        = 1'b0;
                    n_state     = mep_pkg::ST_MAP_OFF;
                end
            end
            mep_pkg::ST_MAP_OFF: begin
                o_cmd.mul_sel = mep_pkg::MUL_OFF;
                o_cmd.im      = r_im;
                n_state       = mep_pkg::ST_MAP_T;
            end
            mep_pkg::ST_MAP_T: begin
                o_cmd.ld_t = 1'b1;
                o_cmd.im   = r_im;
                n_state    = mep_pkg::ST_MAP_ZOOM;
            end
            mep_pkg::ST_MAP_ZOOM: begin
                o_cmd.mul_sel = mep_pkg::MUL_ZOOM;
                n_state       = mep_pkg::ST_MAP_C;
            end
            mep_pkg::ST_MAP_C: begin
                o_cmd.ld_c = 1'b1;
                o_cmd.im   = r_im;
                // The real part is mapped first, then the same four steps run again.
                if (r_im) begin
                    n_state = mep_pkg::ST_IT_XX;
                end else begin
                    n_im    = 1'b1;
                    n_state = mep_pkg::ST_MAP_OFF;
                end
            end
            mep_pkg::ST_IT_XX: begin
                o_cmd.mul_sel = mep_pkg::MUL_XX;
                n_state       = mep_pkg::ST_IT_YY;
            end
            mep_pkg::ST_IT_YY: begin
                o_cmd.mul_sel = mep_pkg::MUL_YY;
                o_cmd.ld_x2   = 1'b1;
                n_state       = mep_pkg::ST_IT_XY;
            end
            mep_pkg::ST_IT_XY: begin
                o_cmd.mul_sel = mep_pkg::MUL_XY;
                o_cmd.ld_y2   = 1'b1;
                n_state       = mep_pkg::ST_IT_CHK;
            end
            mep_pkg::ST_IT_CHK: begin
                o_cmd.upd = 1'b1;
                if (i_stat.escaped || i_stat.last) begin
                    n_bit   = TOP_BIT;
                    n_state = mep_pkg::ST_COEF;
                end else begin
                    n_state = mep_pkg::ST_IT_XX;
                end
            end
            mep_pkg::ST_COEF: begin
                o_cmd.coef_step = 1'b1;
                o_cmd.coef_bit  = r_bit;
                if (r_bit == '0) begin
                    n_state = mep_pkg::ST_DONE;
                end else begin
                    n_bit = r_bit - 3'd1;
                end
            end
            mep_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = mep_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mep_pkg::ST_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.ld_out || (r_out_valid && !i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == mep_pkg::ST_IDLE);

endmodule

// ----- hdl/mep_dp.sv -----
// Datapath of the escape-time engine: configuration registers, one shared signed
// 32x32 multiplier, the iterate registers, the colour search and the result word.
// Uses mep_pkg; driven by mep_ctrl.
module mep_dp #(
    parameter int MAX_ITER   = mep_pkg::MAX_ITER_DEF,
    parameter int IMG_WIDTH  = mep_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = mep_pkg::IMG_HEIGHT_DEF,
    parameter int FRAC_BITS  = mep_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mep_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic [9:0]                    i_pixel_col,
    input  logic [9:0]                    i_pixel_row,
    input  mep_pkg::t_cmd                 i_cmd,
    output mep_pkg::t_stat                o_stat,
    output logic [8:0]                    o_iter_count,
    output logic                          o_in_set,
    output logic [31:0]                   o_argb_color
);

    localparam int NW = $clog2(MAX_ITER + 1);
    localparam int SW = 64 - FRAC_BITS;
    localparam int OW = mep_pkg::OFF_W;
    localparam int SATW = mep_pkg::SAT_W;
    localparam logic signed [OW-1:0] HALF_W = OW'(IMG_WIDTH / 2);
    localparam logic signed [OW-1:0] HALF_H = OW'(IMG_HEIGHT / 2);
    localparam logic [NW-1:0] N_LAST = NW'(MAX_ITER - 1);
    localparam logic [NW-1:0] N_MAX  = NW'(MAX_ITER);
    localparam mep_pkg::t_thr_tab THR_TAB = mep_pkg::thr_table(MAX_ITER);

    // Configuration.
    logic signed [31:0] r_center_re, r_center_im, r_zoom;
    logic [30:0]        r_step_re, r_step_im, r_bound;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_re <= mep_pkg::RST_CENTER_RE;
            r_center_im <= mep_pkg::RST_CENTER_IM;
            r_zoom      <= mep_pkg::RST_ZOOM;
            r_step_re   <= mep_pkg::RST_STEP_RE;
            r_step_im   <= mep_pkg::RST_STEP_IM;
            r_bound     <= mep_pkg::RST_BOUND;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mep_pkg::CFG_CENTER_RE: r_center_re <= i_cfg_data;
                mep_pkg::CFG_CENTER_IM: r_center_im <= i_cfg_data;
                mep_pkg::CFG_ZOOM:      r_zoom      <= i_cfg_data;
                mep_pkg::CFG_STEP_RE:   r_step_re   <= i_cfg_data[30:0];
                mep_pkg::CFG_STEP_IM:   r_step_im   <= i_cfg_data[30:0];
                mep_pkg::CFG_BOUND:     r_bound     <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Working registers.
    logic [9:0]          r_col, r_row;
    logic signed [63:0]  r_prod;
    logic signed [31:0]  r_t, r_cre, r_cim, r_x, r_y;
    logic signed [SW-1:0] r_x2, r_y2;
    logic [NW-1:0]       r_n;
    logic [7:0]          r_k;
    logic [8:0]          r_iter;
    logic                r_in_set;
    logic [31:0]         r_argb;

    logic signed [OW-1:0] off_re, off_im, off_sel;
    logic signed [31:0]   mul_a, mul_b;
    logic signed [63:0]   prod;
    logic signed [SW-1:0] prod_q;
    logic signed [31:0]   t_new, c_new, r2, x_new, y_new;
    logic [7:0]           trial;

    assign off_re  = $signed({{(OW - 10){1'b0}}, r_col}) - HALF_W;
    assign off_im  = $signed({{(OW - 10){1'b0}}, r_row}) - HALF_H;
    assign off_sel = i_cmd.im ? off_im : off_re;

    always_comb begin
        case (i_cmd.mul_sel)
            mep_pkg::MUL_OFF: begin
                mul_a = 32'(off_sel);
                mul_b = i_cmd.im ? $signed({1'b0, r_step_im}) : $signed({1'b0, r_step_re});
            end
            mep_pkg::MUL_ZOOM: begin
                mul_a = r_t;
                mul_b = r_zoom;
            end
            mep_pkg::MUL_XX: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            mep_pkg::MUL_YY: begin
                mul_a = r_y;
                mul_b = r_y;
            end
            mep_pkg::MUL_XY: begin
                mul_a = r_x;
                mul_b = r_y;
            end
            default: begin
                mul_a = r_x;
                mul_b = r_y;
            end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);

    // Dropping the low fraction bits of a two's complement value rounds toward minus infinity.
    assign prod_q = $signed(r_prod[63:FRAC_BITS]);

    assign t_new = mep_pkg::sat32(SATW'(r_prod)
                   + SATW'(i_cmd.im ? r_center_im : r_center_re));
    assign c_new = mep_pkg::sat32(SATW'(prod_q));
    assign r2    = mep_pkg::sat32(SATW'(r_x2) + SATW'(r_y2));
    assign x_new = mep_pkg::sat32(SATW'(r_x2) - SATW'(r_y2) + SATW'(r_cre));
    assign y_new = mep_pkg::sat32(SATW'(prod_q) + SATW'(prod_q) + SATW'(r_cim));

    assign o_stat.escaped = (r2 > $signed({1'b0, r_bound}));
    assign o_stat.last    = (r_n == N_LAST);

    assign trial = r_k | (8'd1 << i_cmd.coef_bit);

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        if (i_cmd.start) begin
            r_col <= i_pixel_col;
            r_row <= i_pixel_row;
            r_n   <= '0;
            r_k   <= '0;
        end
        if (i_cmd.ld_t) begin
            r_t <= t_new;
        end
        if (i_cmd.ld_c) begin
            if (i_cmd.im) begin
                r_cim <= c_new;
                r_y   <= c_new;
            end else begin
                r_cre <= c_new;
                r_x   <= c_new;
            end
        end
        if (i_cmd.ld_x2) begin
            r_x2 <= prod_q;
        end
        if (i_cmd.ld_y2) begin
            r_y2 <= prod_q;
        end
        // The x*y product sits in r_prod when the radius test runs.
        if (i_cmd.upd && !o_stat.escaped) begin
            r_x <= x_new;
            r_y <= y_new;
            r_n <= r_n + NW'(1);
        end
        // One bit of the coefficient per step, from the top.
        if (i_cmd.coef_step && (THR_TAB[trial] <= mep_pkg::THR_W'(r_n))) begin
            r_k <= trial;
        end
        if (i_cmd.ld_out) begin
            r_iter   <= 9'(r_n);
            r_in_set <= (r_n == N_MAX);
            r_argb   <= (r_n == N_MAX) ? mep_pkg::ARGB_BLACK
                        : {8'hFF, r_k, 1'b0, r_k[0], 6'b000000, ~r_k};
        end
    end

    assign o_iter_count = r_iter;
    assign o_in_set     = r_in_set;
    assign o_argb_color = r_argb;

endmodule

// ----- hdl/mep_checker.sv -----
// Port-level checks of the escape-time engine, attached to the top level by bind.
// Depends on mandelbrot_escape_pixel_top_assert.svh.
`include "mandelbrot_escape_pixel_top_assert.svh"

module mep_checker #(
    parameter int MAX_ITER = mep_pkg::MAX_ITER_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [8:0]  o_iter_count,
    input logic        o_in_set,
    input logic [31:0] o_argb_color
);

    localparam logic [8:0] ITER_FULL = 9'(MAX_ITER);

    // No word is offered right after reset.
    `MEP_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_out_valid, "word valid after reset")

    // A pixel is worked on alone: input closes right after an accept.
    `MEP_ASSERT_RUN(a_one_at_a_time, (i_in_valid && o_in_ready) |=> !o_in_ready, "input open while busy")

    // A pixel in the set is opaque black and reports the full count.
    `MEP_ASSERT_RUN(a_in_set_word, (o_out_valid && o_in_set) |-> (o_argb_color == 32'hFF00_0000) && (o_iter_count == ITER_FULL), "in-set word malformed")

    // An escaped pixel follows the ramp: opaque, blue is the complement of red, green from red's LSB.
    `MEP_ASSERT_RUN(a_ramp_word, (o_out_valid && !o_in_set) |-> (o_argb_color[31:24] == 8'hFF) && (o_argb_color[7:0] == ~o_argb_color[23:16]) && (o_argb_color[15:8] == {1'b0, o_argb_color[16], 6'b000000}), "ramp colour malformed")

    // A stalled word holds.
    `MEP_ASSERT_RUN(a_out_hold, (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_argb_color) && $stable(o_iter_count) && $stable(o_in_set), "stalled word changed")

endmodule

bind mandelbrot_escape_pixel_top mep_checker #(.MAX_ITER(MAX_ITER)) u_mep_checker (.*);
